@@ rtl/tis_pkg.sv @@
// ----------------------------------------------------------------------------
// tis_pkg: shared types and constants for the triangle isoline block
// Word layouts of both channels, the queue entry and the state encodings.
// ----------------------------------------------------------------------------
package tis_pkg;

    localparam int COORD_W          = 24;
    localparam int DIST_W           = 24;
    localparam int CNT_W            = 7;
    localparam int MAX_SEGMENTS_DEF = 33;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam logic [DIST_W-1:0] STEP_RESET = 24'd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
        logic        [DIST_W-1:0]  first_dist;
        logic        [DIST_W-1:0]  second_dist;
        logic        [DIST_W-1:0]  third_dist;
    } tri_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic        [DIST_W-1:0]  level_index;
        logic                      last_segment;
        logic                      truncated;
    } seg_word_t;

    typedef struct packed {
        tri_word_t            tri_data;
        logic [DIST_W-1:0]    k;
        logic [DIST_W-1:0]    lvl;
        logic [DIST_W-1:0]    step;
        logic [CNT_W-1:0]     count;
        logic                 trunc;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV_LO,
        F_DIV_HI,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_WAIT,
        B_OUT
    } back_state_t;

endpackage

@@ rtl/tis_div.sv @@
// ----------------------------------------------------------------------------
// tis_div: restoring divider, one quotient bit per cycle
// The high part of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module tis_div #(
    parameter int Q_W = 24,
    parameter int D_W = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [D_W-1:0] hi,
    input  logic [Q_W-1:0] lo,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [Q_W-1:0] quo,
    output logic [D_W-1:0] rem
);

    localparam int CW = (Q_W > 1) ? $clog2(Q_W) : 1;

    logic [D_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0] den_reg;
    logic [CW-1:0]  cnt_reg;
    logic           run_reg;
    logic           done_reg;
    logic [D_W:0]   trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[Q_W-1]} - {1'b0, den_reg};
        if (!trial[D_W])
        begin
            rem_next = trial[D_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[D_W-2:0], quo_reg[Q_W-1]};
            quo_next = {quo_reg[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(Q_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= hi;
            quo_reg <= lo;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/tis_fifo.sv @@
// ----------------------------------------------------------------------------
// tis_fifo: short queue of classified triangles
// Sits between the front and back parts so that each can stall on its own.
// ----------------------------------------------------------------------------
module tis_fifo
    import tis_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [NW-1:0] num_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (num_reg == NW'(DEPTH));
    assign empty    = (num_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            num_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                num_reg <= num_reg + 1'b1;
            else if (do_pop && !do_push)
                num_reg <= num_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_data;
    end

endmodule

@@ rtl/tis_front.sv @@
// ----------------------------------------------------------------------------
// tis_front: accepts triangles and works out their level range
// Divides the least and greatest distance by the step and queues any level range found.
// ----------------------------------------------------------------------------
module tis_front
    import tis_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DIST_W-1:0] iso_step,
    input  logic              tri_valid,
    output logic              tri_ready,
    input  tri_word_t         tri_word,
    output logic              push,
    output job_t              push_data,
    input  logic              full
);

    front_state_t      state_reg, state_next;
    tri_word_t         tri_reg;
    logic [DIST_W-1:0] dmin_reg, dmax_reg, step_reg;
    logic [DIST_W-1:0] qlo_reg, rlo_reg;
    job_t              job_reg, job_next;
    logic              job_load;
    logic              lo_load;
    logic              tri_load;

    logic [DIST_W-1:0] dmin_c, dmax_c, step_c;
    logic              div_start, div_done;
    logic [DIST_W-1:0] div_lo, div_den, div_quo, div_rem;
    logic [DIST_W:0]   kmin, kmax, levels;
    logic              trunc;

    always_comb
    begin
        dmin_c = tri_word.first_dist;
        dmax_c = tri_word.first_dist;
        if (tri_word.second_dist < dmin_c) dmin_c = tri_word.second_dist;
        if (tri_word.second_dist > dmax_c) dmax_c = tri_word.second_dist;
        if (tri_word.third_dist < dmin_c) dmin_c = tri_word.third_dist;
        if (tri_word.third_dist > dmax_c) dmax_c = tri_word.third_dist;
        step_c = (iso_step == '0) ? DIST_W'(1) : iso_step;
    end

    assign div_lo  = (state_reg == F_IDLE) ? dmin_c : dmax_reg;
    assign div_den = (state_reg == F_IDLE) ? step_c : step_reg;

    tis_div #(
        .Q_W(DIST_W),
        .D_W(DIST_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .hi    ('0),
        .lo    (div_lo),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_comb
    begin
        kmin   = {1'b0, qlo_reg} + {{DIST_W{1'b0}}, (rlo_reg != '0)};
        kmax   = {1'b0, div_quo};
        levels = kmax - kmin + 1'b1;
        trunc  = levels > (DIST_W + 1)'(MAX_SEGMENTS);
        job_next.tri_data = tri_reg;
        job_next.k        = kmin[DIST_W-1:0];
        job_next.lvl      = (rlo_reg == '0) ? dmin_reg : dmin_reg - rlo_reg + step_reg;
        job_next.step     = step_reg;
        job_next.count    = trunc ? CNT_W'(MAX_SEGMENTS) : levels[CNT_W-1:0];
        job_next.trunc    = trunc;
    end

    always_comb
    begin
        state_next = state_reg;
        tri_ready  = 1'b0;
        div_start  = 1'b0;
        tri_load   = 1'b0;
        lo_load    = 1'b0;
        job_load   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                tri_ready = 1'b1;
                if (tri_valid && (dmin_c != dmax_c))
                begin
                    tri_load   = 1'b1;
                    div_start  = 1'b1;
                    state_next = F_DIV_LO;
                end
            end
            F_DIV_LO:
            begin
                if (div_done)
                begin
                    lo_load    = 1'b1;
                    div_start  = 1'b1;
                    state_next = F_DIV_HI;
                end
            end
            F_DIV_HI:
            begin
                if (div_done)
                begin
                    if (kmax >= kmin)
                    begin
                        job_load   = 1'b1;
                        state_next = F_PUSH;
                    end
                    else
                        state_next = F_IDLE;
                end
            end
            F_PUSH:
            begin
                push = 1'b1;
                if (!full)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (tri_load)
        begin
            tri_reg  <= tri_word;
            dmin_reg <= dmin_c;
            dmax_reg <= dmax_c;
            step_reg <= step_c;
        end
        if (lo_load)
        begin
            qlo_reg <= div_quo;
            rlo_reg <= div_rem;
        end
        if (job_load)
            job_reg <= job_next;
    end

    assign push_data = job_reg;

endmodule

@@ rtl/tis_back.sv @@
// ----------------------------------------------------------------------------
// tis_back: walks the levels of a queued triangle and builds its segments
// One multiply and one shared divider interpolate each crossing coordinate.
// ----------------------------------------------------------------------------
module tis_back
    import tis_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  job_t      pop_data,
    output logic      pop,
    output logic      seg_valid,
    input  logic      seg_ready,
    output seg_word_t seg_word
);

    localparam int SUM_W = 2 * DIST_W + 1;
    localparam int Q_W   = COORD_W + 1;

    back_state_t             state_reg, state_next;
    job_t                    job_reg;
    logic                    pt_reg;
    logic [1:0]              c_reg;
    logic signed [2*Q_W-1:0] prod_reg;
    logic signed [DIST_W:0]  den_reg;
    logic signed [COORD_W-1:0] a_reg;
    logic [COORD_W-1:0]      pts_reg [6];
    seg_word_t               out_reg;
    logic                    out_valid_reg;

    logic                    job_load, mul_load, pt_store, out_load, lvl_adv;
    logic [DIST_W-1:0]       vd [3];
    logic signed [COORD_W-1:0] vc [3][3];
    logic [2:0]              hit;
    logic [1:0]              e0, e1, edge_sel, edge_nb;
    logic [DIST_W-1:0]       pa, pb;
    logic signed [COORD_W-1:0] ca, cb;
    logic signed [Q_W-1:0]   num, diff;
    logic signed [DIST_W:0]  den_c;
    logic signed [2*Q_W-1:0] prod_c;
    logic [2*Q_W-1:0]        up_full;
    logic [DIST_W:0]         ud_full;
    logic [SUM_W-1:0]        sum;
    logic                    div_start, div_done;
    logic [Q_W-1:0]          div_quo;
    logic [DIST_W-1:0]       div_rem;
    logic [COORD_W+1:0]      res;
    logic [2:0]              pidx;
    logic                    out_free;

    always_comb
    begin
        vd[0] = job_reg.tri_data.first_dist;
        vd[1] = job_reg.tri_data.second_dist;
        vd[2] = job_reg.tri_data.third_dist;
        vc[0][0] = job_reg.tri_data.first_x;
        vc[0][1] = job_reg.tri_data.first_y;
        vc[0][2] = job_reg.tri_data.first_z;
        vc[1][0] = job_reg.tri_data.second_x;
        vc[1][1] = job_reg.tri_data.second_y;
        vc[1][2] = job_reg.tri_data.second_z;
        vc[2][0] = job_reg.tri_data.third_x;
        vc[2][1] = job_reg.tri_data.third_y;
        vc[2][2] = job_reg.tri_data.third_z;
        for (int e = 0; e < 3; e++)
        begin
            hit[e] = !((vd[e] > job_reg.lvl) && (vd[(e + 1) % 3] > job_reg.lvl))
                  && !((vd[e] < job_reg.lvl) && (vd[(e + 1) % 3] < job_reg.lvl))
                  && !((vd[e] == job_reg.lvl) && (vd[(e + 1) % 3] == job_reg.lvl))
                  && (vd[e] != vd[(e + 1) % 3]);
        end
    end

    always_comb
    begin
        e0 = hit[0] ? 2'd0 : (hit[1] ? 2'd1 : 2'd2);
        e1 = (hit[0] && hit[1]) ? 2'd1 : 2'd2;
        edge_sel = pt_reg ? e1 : e0;
        edge_nb  = (edge_sel == 2'd2) ? 2'd0 : edge_sel + 2'd1;
        pa = vd[edge_sel];
        pb = vd[edge_nb];
        ca = vc[edge_sel][c_reg];
        cb = vc[edge_nb][c_reg];
        num    = $signed({1'b0, job_reg.lvl}) - $signed({1'b0, pa});
        diff   = $signed({cb[COORD_W-1], cb}) - $signed({ca[COORD_W-1], ca});
        den_c  = $signed({1'b0, pb}) - $signed({1'b0, pa});
        prod_c = num * diff;
    end

    always_comb
    begin
        up_full = prod_reg[2*Q_W-1] ? -prod_reg : prod_reg;
        ud_full = den_reg[DIST_W] ? -den_reg : den_reg;
        sum = {1'b0, up_full[2*DIST_W-1:0]}
            + {{(DIST_W + 2){1'b0}}, ud_full[DIST_W-1:1]};
        if (prod_reg[2*Q_W-1] ^ den_reg[DIST_W])
            res = {{2{a_reg[COORD_W-1]}}, a_reg} - {1'b0, div_quo};
        else
            res = {{2{a_reg[COORD_W-1]}}, a_reg} + {1'b0, div_quo};
        pidx = pt_reg ? (3'd3 + {1'b0, c_reg}) : {1'b0, c_reg};
    end

    tis_div #(
        .Q_W(Q_W),
        .D_W(DIST_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .hi    (sum[SUM_W-1:Q_W]),
        .lo    (sum[Q_W-1:0]),
        .den   (ud_full[DIST_W-1:0]),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign out_free = !out_valid_reg || seg_ready;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        job_load   = 1'b0;
        mul_load   = 1'b0;
        div_start  = 1'b0;
        pt_store   = 1'b0;
        out_load   = 1'b0;
        lvl_adv    = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    job_load   = 1'b1;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                mul_load   = 1'b1;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                div_start  = 1'b1;
                state_next = B_WAIT;
            end
            B_WAIT:
            begin
                if (div_done)
                begin
                    pt_store = 1'b1;
                    if (pt_reg && (c_reg == 2'd2))
                        state_next = B_OUT;
                    else
                        state_next = B_MUL;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    lvl_adv  = 1'b1;
                    state_next = (job_reg.count == CNT_W'(1)) ? B_IDLE : B_MUL;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            pt_reg        <= 1'b0;
            c_reg         <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (seg_ready)
                out_valid_reg <= 1'b0;
            if (job_load || lvl_adv)
            begin
                pt_reg <= 1'b0;
                c_reg  <= 2'd0;
            end
            else if (pt_store)
            begin
                if (c_reg == 2'd2)
                begin
                    c_reg  <= 2'd0;
                    pt_reg <= 1'b1;
                end
                else
                    c_reg <= c_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= pop_data;
        else if (lvl_adv)
        begin
            job_reg.count <= job_reg.count - 1'b1;
            job_reg.k     <= job_reg.k + 1'b1;
            job_reg.lvl   <= job_reg.lvl + job_reg.step;
        end
        if (mul_load)
        begin
            prod_reg <= prod_c;
            den_reg  <= den_c;
            a_reg    <= ca;
        end
        if (pt_store)
            pts_reg[pidx] <= res[COORD_W-1:0];
        if (out_load)
        begin
            out_reg.start_x      <= pts_reg[0];
            out_reg.start_y      <= pts_reg[1];
            out_reg.start_z      <= pts_reg[2];
            out_reg.end_x        <= pts_reg[3];
            out_reg.end_y        <= pts_reg[4];
            out_reg.end_z        <= pts_reg[5];
            out_reg.level_index  <= job_reg.k;
            out_reg.last_segment <= (job_reg.count == CNT_W'(1));
            out_reg.truncated    <= job_reg.trunc;
        end
    end

    assign seg_valid = out_valid_reg;
    assign seg_word  = out_reg;

endmodule

@@ rtl/triangle_isoline_segments.sv @@
// ----------------------------------------------------------------------------
// triangle_isoline_segments: contour segments of one triangle per word
// Top level joining the classifying front, the queue and the segment back.
// ----------------------------------------------------------------------------
// Usage:
// A triangle word enters on tri_valid/tri_ready. The block emits one segment
// word on seg_valid/seg_ready for each contour level k*iso_step between the
// least and greatest vertex distance, lowest level first, at most
// MAX_SEGMENTS of them; the final one carries last_segment. A triangle whose
// distances are all equal, or that spans no level, gives no word.
// The front performs two step divisions per triangle.
// The back performs six interpolations per segment, each a multiply and a
// division on one shared divider.
// A queue of QUEUE_DEPTH triangles lets the front take new words while the
// back works or while a finished segment waits in the output register.
// When the receiver stalls the segment word holds and the back waits.
// iso_step is written on cfg_valid/cfg_ready (always ready); the user must write it only while idle (not enforced).
// Reset clears all control state and sets iso_step to 1.0.
// ----------------------------------------------------------------------------
module triangle_isoline_segments
    import tis_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIST_W-1:0] cfg_data,
    input  logic              tri_valid,
    output logic              tri_ready,
    input  tri_word_t         tri_word,
    output logic              seg_valid,
    input  logic              seg_ready,
    output seg_word_t         seg_word
);

    logic [DIST_W-1:0] iso_step_reg;
    logic              push, full, pop, empty;
    job_t              push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iso_step_reg <= STEP_RESET;
        else if (cfg_valid)
            iso_step_reg <= cfg_data;
    end

    tis_front #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .iso_step  (iso_step_reg),
        .tri_valid (tri_valid),
        .tri_ready (tri_ready),
        .tri_word  (tri_word),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    tis_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    tis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg_word  (seg_word)
    );

endmodule

@@ rtl/tis_checker.sv @@
// ----------------------------------------------------------------------------
// tis_checker: port level checks for the triangle isoline block
// Watches the segment stream for stall holding, ordering and flag consistency.
// ----------------------------------------------------------------------------
module tis_checker
    import tis_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      seg_valid,
    input logic      seg_ready,
    input seg_word_t seg_word
);

    logic              mid_reg;
    logic              trunc_reg;
    logic [DIST_W-1:0] level_reg;
    logic              seg_take;

    assign seg_take = seg_valid && seg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg   <= 1'b0;
            trunc_reg <= 1'b0;
            level_reg <= '0;
        end
        else if (seg_take)
        begin
            mid_reg   <= !seg_word.last_segment;
            trunc_reg <= seg_word.truncated;
            level_reg <= seg_word.level_index;
        end
    end

    // A stalled segment word must hold still.
    a_seg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_ready |=> seg_valid && $stable(seg_word))
        else $error("segment word changed while stalled");

    // Within one triangle the levels rise by one.
    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        seg_take && mid_reg |-> seg_word.level_index == level_reg + 1'b1)
        else $error("segment level does not follow the previous one");

    // The truncation flag is the same on every segment of a triangle.
    a_trunc_same: assert property (@(posedge clk) disable iff (!rst_n)
        seg_take && mid_reg |-> seg_word.truncated == trunc_reg)
        else $error("truncation flag changed within a triangle");

endmodule

bind triangle_isoline_segments tis_checker u_tis_checker (.*);
